// ===== rtl/dragonfly_next_port_router_assert.svh =====
// Assertion macros used by the checker file of the next-port router.
// No dependencies; include by bare file name.
`ifndef DRAGONFLY_NEXT_PORT_ROUTER_ASSERT_SVH
`define DRAGONFLY_NEXT_PORT_ROUTER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define DFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// consequent checked also while reset is asserted
`define DFR_ASSERT_RST(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dfr_pkg.sv =====
// Types, constants and helper functions of the dragonfly next-port router.
// No dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int TIDX_W      = 7;
  localparam int ENTRY_W     = 11;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_HOSTS    = 3'd0,
    REG_ROUTERS  = 3'd1,
    REG_NGROUPS  = 3'd2,
    REG_SLICES   = 3'd3,
    REG_RELATIVE = 3'd4,
    REG_OWNGRP   = 3'd5,
    REG_OWNRTR   = 3'd6
  } reg_idx_t;

  typedef enum logic {
    FUNC_ROUTE = 1'b0,
    FUNC_LOAD  = 1'b1
  } func_t;

  typedef struct packed {
    logic [5:0] host_cnt;
    logic [5:0] rtr_cnt;
    logic [5:0] grp_cnt;
    logic [2:0] slices_per_group;
    logic       relative_mode;
    logic [4:0] own_group;
    logic [4:0] own_router;
  } cfg_t;

  typedef struct packed {
    logic [2:0] idx;
    logic [5:0] wdata;
  } cfg_word_t;

  typedef struct packed {
    logic       func;
    logic [5:0] in_port;
    logic [3:0] in_vc;
    logic [4:0] origin_grp;
    logic [4:0] dest_group;
    logic [4:0] dest_router;
    logic [5:0] dest_host;
    logic [4:0] via_grp;
    logic [1:0] gslice;
    logic [6:0] table_index;
    logic [4:0] table_router;
    logic [5:0] table_port;
  } req_t;

  typedef struct packed {
    logic [5:0] out_port;
    logic [3:0] out_vc;
  } rsp_t;

  // classified word passed from front to back
  typedef struct packed {
    logic                  is_load;
    logic                  use_tbl;
    logic [TIDX_W-1:0]     tidx;
    logic [ENTRY_W-1:0]    entry;
    logic [5:0]            port;
    logic [3:0]            vc;
  } work_t;

  // port toward router r of own group
  function automatic logic [5:0] toward_router(input logic [5:0] hosts,
                                               input logic [4:0] own,
                                               input logic [4:0] r);
    logic [5:0] t;
    t = hosts + {1'b0, r};
    if (r > own) begin
      t = t - 6'd1;
    end
    return t;
  endfunction

endpackage

// ===== rtl/dfr_chan_if.sv =====
// Valid/ready channel carrying one payload word of type T.
// Depends on nothing; payload types come from dfr_pkg at instantiation.
`timescale 1ns / 1ps

interface dfr_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/dfr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/dfr_front.sv =====
// Front end: accepts request words, classifies the input port and works out
// either the final port or the table index. Depends on dfr_pkg, dfr_chan_if.
`timescale 1ns / 1ps

module dfr_front (
  dfr_chan_if.sink        req,
  input  dfr_pkg::cfg_t   cfg,
  input  logic            q_full,
  output logic            push,
  output dfr_pkg::work_t  push_word
);

  dfr_pkg::req_t r;
  logic          is_host;
  logic          is_local;
  logic          bump;
  logic          use_tbl;
  logic [4:0]    tgt_group;
  logic [4:0]    tgt_router;
  logic          to_host;
  logic [6:0]    remap;
  logic [6:0]    tidx;

  assign r         = req.data;
  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  always_comb begin
    is_host    = r.in_port < cfg.host_cnt;
    is_local   = ({1'b0, r.in_port} + 7'd1) <
                 ({1'b0, cfg.host_cnt} + {1'b0, cfg.rtr_cnt});
    bump       = 1'b0;
    use_tbl    = 1'b0;
    to_host    = 1'b0;
    tgt_group  = r.dest_group;
    tgt_router = r.dest_router;

    if (is_host) begin
      if (r.dest_group == r.origin_grp) begin
        if (r.dest_router == cfg.own_router) begin
          to_host = 1'b1;
        end else begin
          tgt_router = r.via_grp;
        end
      end else begin
        use_tbl   = 1'b1;
        tgt_group = r.via_grp;
      end
    end else if (is_local) begin
      if (r.dest_group == cfg.own_group) begin
        if (r.dest_router == cfg.own_router) begin
          to_host = 1'b1;
        end else begin
          bump = 1'b1;
        end
      end else begin
        use_tbl = 1'b1;
        if (r.via_grp != cfg.own_group && r.via_grp != r.dest_group) begin
          tgt_group = r.via_grp;
        end
      end
    end else begin
      bump = 1'b1;
      if (r.dest_group == cfg.own_group) begin
        to_host = (r.dest_router == cfg.own_router);
      end else begin
        use_tbl = 1'b1;
      end
    end

    // group remap, wrapping modulo the table depth
    if (!cfg.relative_mode) begin
      remap = (tgt_group >= cfg.own_group) ? ({2'b0, tgt_group} - 7'd1)
                                           : {2'b0, tgt_group};
    end else if (tgt_group > cfg.own_group) begin
      remap = {2'b0, tgt_group} - {2'b0, cfg.own_group} - 7'd1;
    end else begin
      remap = {1'b0, cfg.grp_cnt} - {2'b0, cfg.own_group} + {2'b0, tgt_group} - 7'd1;
    end
    tidx = 7'(remap * {4'b0, cfg.slices_per_group}) + {5'b0, r.gslice};

    push_word.is_load = (r.func == dfr_pkg::FUNC_LOAD);
    push_word.use_tbl = use_tbl;
    push_word.tidx    = push_word.is_load ? r.table_index : tidx;
    push_word.entry   = {r.table_router, r.table_port};
    push_word.port    = to_host ? r.dest_host
                      : dfr_pkg::toward_router(cfg.host_cnt, cfg.own_router,
                                               tgt_router);
    push_word.vc      = (bump && r.in_vc != 4'hF) ? r.in_vc + 4'd1 : r.in_vc;
  end

endmodule

// ===== rtl/dfr_queue.sv =====
// Small FIFO between front and back, registers only.
// Depends on nothing; word type given by parameter.
`timescale 1ns / 1ps

module dfr_queue #(
  parameter int  DEPTH = 2,
  parameter type T     = logic
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  T     push_word,
  input  logic pop,
  output T     head,
  output logic empty,
  output logic full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T              mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(DEPTH));
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

// ===== rtl/dfr_back.sv =====
// Back end: writes table entries, reads the table for global routes and
// holds the result word. Depends on dfr_pkg, dfr_chan_if, dfr_ram.
`timescale 1ns / 1ps

module dfr_back (
  input  logic           clk,
  input  logic           rst,
  input  dfr_pkg::cfg_t  cfg,
  input  dfr_pkg::work_t head,
  input  logic           empty,
  output logic           pop,
  dfr_chan_if.source     rsp
);

  logic                         out_free;
  logic                         s1_free;
  logic                         s1_valid;
  logic                         s1_use_tbl;
  logic [5:0]                   s1_port;
  logic [3:0]                   s1_vc;
  logic                         rd_en;
  logic                         wr_en;
  logic [dfr_pkg::ENTRY_W-1:0]  rdata;
  logic [4:0]                   ent_router;
  logic [5:0]                   ent_port;
  logic [5:0]                   port_sel;
  logic                         out_valid;
  dfr_pkg::rsp_t                out_word;

  assign out_free = !out_valid || rsp.ready;
  assign s1_free  = !s1_valid || out_free;
  assign pop      = !empty && (head.is_load || s1_free);
  assign wr_en    = pop && head.is_load;
  assign rd_en    = pop && !head.is_load;

  dfr_ram #(
    .WIDTH (dfr_pkg::ENTRY_W),
    .DEPTH (dfr_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (head.tidx),
    .wdata (head.entry),
    .re    (rd_en),
    .raddr (head.tidx),
    .rdata (rdata)
  );

  assign ent_router = rdata[10:6];
  assign ent_port   = rdata[5:0];

  always_comb begin
    if (!s1_use_tbl) begin
      port_sel = s1_port;
    end else if (ent_router == cfg.own_router) begin
      port_sel = ent_port;
    end else begin
      port_sel = dfr_pkg::toward_router(cfg.host_cnt, cfg.own_router, ent_router);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= rd_en;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && rd_en) begin
      s1_use_tbl <= head.use_tbl;
      s1_port    <= head.port;
      s1_vc      <= head.vc;
    end
    if (out_free && s1_valid) begin
      out_word.out_port <= port_sel;
      out_word.out_vc   <= s1_vc;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

endmodule

// ===== rtl/dragonfly_next_port_router.sv =====
// Top level of the dragonfly next-port router: configuration registers,
// front end, queue and back end. Depends on dfr_pkg, dfr_chan_if and submodules.
//
//   channel  dir  payload       handshake
//   req      in   dfr_pkg::req_t  valid/ready
//   rsp      out  dfr_pkg::rsp_t  valid/ready
//   cfg      in   cfg_word_t      valid/ready (always ready)
//
// One word per cycle sustained while rsp is ready; the queue pops at most one word a cycle.
// A route word taken on req passes the queue, the s1 table read stage and the output register before rsp.valid rises.
// Load words write the table and give no result.
// Reset empties the pipeline and restores default settings; the table is not cleared.
// A stalled rsp holds its word and backs up through the queue to req.ready.
`timescale 1ns / 1ps

module dragonfly_next_port_router #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  dfr_chan_if.sink   req,
  dfr_chan_if.source rsp,
  dfr_chan_if.sink   cfg
);

  dfr_pkg::cfg_t   cfg_q;
  dfr_pkg::work_t  push_word;
  dfr_pkg::work_t  head;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.host_cnt          <= 6'd4;
      cfg_q.rtr_cnt           <= 6'd8;
      cfg_q.grp_cnt           <= 6'd9;
      cfg_q.slices_per_group  <= 3'd1;
      cfg_q.relative_mode     <= 1'b0;
      cfg_q.own_group         <= 5'd0;
      cfg_q.own_router        <= 5'd0;
    end else if (cfg.valid) begin
      case (cfg.data.idx)
        dfr_pkg::REG_HOSTS:    cfg_q.host_cnt          <= cfg.data.wdata;
        dfr_pkg::REG_ROUTERS:  cfg_q.rtr_cnt           <= cfg.data.wdata;
        dfr_pkg::REG_NGROUPS:  cfg_q.grp_cnt           <= cfg.data.wdata;
        dfr_pkg::REG_SLICES:   cfg_q.slices_per_group  <= cfg.data.wdata[2:0];
        dfr_pkg::REG_RELATIVE: cfg_q.relative_mode     <= cfg.data.wdata[0];
        dfr_pkg::REG_OWNGRP:   cfg_q.own_group         <= cfg.data.wdata[4:0];
        dfr_pkg::REG_OWNRTR:   cfg_q.own_router        <= cfg.data.wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  dfr_front u_front (
    .req       (req),
    .cfg       (cfg_q),
    .q_full    (q_full),
    .push      (push),
    .push_word (push_word)
  );

  dfr_queue #(
    .DEPTH (QUEUE_DEPTH),
    .T     (dfr_pkg::work_t)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dfr_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_q),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .rsp   (rsp)
  );

endmodule

// ===== rtl/dfr_checker.sv =====
// Port-level checks of the next-port router, bound to the top level.
// Depends on dfr_pkg and dragonfly_next_port_router_assert.svh.
`timescale 1ns / 1ps
`include "dragonfly_next_port_router_assert.svh"

module dfr_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          req_func,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input dfr_pkg::rsp_t rsp_data,
  input logic          cfg_ready
);

  logic [7:0] pending;
  logic       req_route;
  logic       rsp_fire;

  assign req_route = req_valid && req_ready && (req_func == dfr_pkg::FUNC_ROUTE);
  assign rsp_fire  = rsp_valid && rsp_ready;

  // routes taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'b0, req_route} - {7'b0, rsp_fire};
    end
  end

  `DFR_ASSERT_RST(a_rsp_idle_after_rst, clk, rst, !rsp_valid, "rsp valid after reset")
  `DFR_ASSERT_NOW(a_rsp_has_route, clk, rst, rsp_valid, pending != 8'd0, "word without route")
  `DFR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_data), "rsp word dropped or changed")
  `DFR_ASSERT_NOW(a_cfg_ready, clk, rst, 1'b1, cfg_ready, "cfg not ready")

endmodule

bind dragonfly_next_port_router dfr_checker u_dfr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_func  (req.data.func),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data),
  .cfg_ready (cfg.ready)
);
